/* rtl/cbe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// Shared constants and types for the cubic Bezier easing block.
// No dependencies; the stream interfaces and the top level import it.
package cbe_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int NEWTON_STEPS = 10;
	localparam int WORD_W       = FRAC_BITS + 1;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t ONE = word_t'(1) << FRAC_BITS;

	// Control point defaults: x1 = 0.4, x2 = 0.2, y1 = 0, y2 = 1
	localparam word_t CTRL_X1_RST = word_t'((2 * (2 ** FRAC_BITS)) / 5);
	localparam word_t CTRL_X2_RST = word_t'((2 ** FRAC_BITS) / 5);
	localparam word_t CTRL_Y1_RST = '0;
	localparam word_t CTRL_Y2_RST = ONE;

	localparam int CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_CTRL_X1 = 2'd0;
	localparam cfg_idx_t CFG_CTRL_X2 = 2'd1;
	localparam cfg_idx_t CFG_CTRL_Y1 = 2'd2;
	localparam cfg_idx_t CFG_CTRL_Y2 = 2'd3;

	// Saturate a Q1.F word to [0, 1]
	function automatic word_t sat_unit(input word_t v);
		return (v > ONE) ? ONE : v;
	endfunction

endpackage
`default_nettype wire

/* rtl/cbe_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready stream interfaces for the easing block's input and result.
// Depends on cbe_pkg for the payload word type.
interface cbe_linear_if;
	import cbe_pkg::*;
	logic  valid;
	logic  ready;
	word_t linear_t;
	modport source (output valid, output linear_t, input ready);
	modport sink   (input valid, input linear_t, output ready);
endinterface

interface cbe_eased_if;
	import cbe_pkg::*;
	logic  valid;
	logic  ready;
	word_t eased_value;
	modport source (output valid, output eased_value, input ready);
	modport sink   (input valid, input eased_value, output ready);
endinterface
`default_nettype wire

/* rtl/cubic_bezier_easing.sv */
`timescale 1ns / 1ps
`default_nettype none
// Cubic Bezier easing curve evaluator: one shared multiplier under a microcode
// sequencer plus a one-bit-per-cycle restoring divider. Depends on cbe_pkg, cbe_if.
//
// Usage:
//   linear : request channel carrying linear_t (unsigned Q1.16, above one reads as one).
//   eased  : result channel carrying eased_value (unsigned Q1.16, in [0, 1]).
//   cfg_*  : write port for ctrl_x1, ctrl_x2, ctrl_y1, ctrl_y2 (index 0..3); write
//            only while the block is idle. Values above one are stored as one.
// Sequence:
//   One request per evaluation; linear.ready is high only in idle. Each Newton step
//   runs the curve and slope ops on the multiplier, a check, the divider and an update;
//   the final y evaluation runs the curve ops and the finish. A request runs at most
//   NEWTON_STEPS Newton steps; a flat slope ends the steps at its check. The shared
//   multiplier and the serial divider set the length of an evaluation.
// Reset and stalls:
//   arst_n returns the control points to their defaults and empties the result
//   register. A finished result waits in the output register; a new request is
//   taken meanwhile, and its result waits until the previous one has been taken.
module cubic_bezier_easing (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire cbe_pkg::cfg_idx_t cfg_index,
	input  wire cbe_pkg::word_t   cfg_data,
	cbe_linear_if.sink            linear,
	cbe_eased_if.source           eased
);
	import cbe_pkg::*;

	localparam int ACC_W  = FRAC_BITS + 5;
	localparam int PROD_W = 2 * WORD_W;
	localparam int DIV_W  = ACC_W + FRAC_BITS + 2;
	localparam int Q_W    = FRAC_BITS + 3;
	localparam int QCNT_W = $clog2(Q_W);
	localparam int STEP_W = $clog2(NEWTON_STEPS + 1);
	localparam int TN_W   = Q_W + 2;
	localparam int PC_W   = 4;

	localparam logic [PC_W-1:0] PC_LAST_CURVE  = 4'd6;
	localparam logic [PC_W-1:0] PC_LAST_NEWTON = 4'd10;

	localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [Q_W-1:0]    Q_MAX    = Q_W'(1) << (FRAC_BITS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EVAL, ST_CHECK, ST_DIV, ST_UPDATE, ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OPN_T, OPN_MT, OPN_T2, OPN_MT2, OPN_A, OPN_B, OPN_C,
		OPN_P1, OPN_P2, OPN_PD, OPN_PC
	} opnd_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_T2, DST_MT2, DST_A, DST_B, DST_C
	} dest_t;

	typedef enum logic [1:0] {ACC_NONE, ACC_X, ACC_D} accsel_t;
	typedef enum logic [1:0] {WT_1, WT_3, WT_6} weight_t;

	typedef struct packed {
		opnd_t   a;
		opnd_t   b;
		dest_t   dst;
		accsel_t acc;
		weight_t wt;
	} uop_t;

	// Curve terms first (ops 0..6), slope terms after (ops 7..10)
	function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '{a: OPN_T, b: OPN_T, dst: DST_NONE, acc: ACC_NONE, wt: WT_1};
		unique case (pc)
			4'd0:  u = '{a: OPN_T,   b: OPN_T,  dst: DST_T2,   acc: ACC_NONE, wt: WT_1};
			4'd1:  u = '{a: OPN_T2,  b: OPN_T,  dst: DST_NONE, acc: ACC_X,    wt: WT_1};
			4'd2:  u = '{a: OPN_MT,  b: OPN_MT, dst: DST_MT2,  acc: ACC_NONE, wt: WT_1};
			4'd3:  u = '{a: OPN_MT2, b: OPN_T,  dst: DST_A,    acc: ACC_NONE, wt: WT_1};
			4'd4:  u = '{a: OPN_A,   b: OPN_P1, dst: DST_NONE, acc: ACC_X,    wt: WT_3};
			4'd5:  u = '{a: OPN_MT,  b: OPN_T2, dst: DST_B,    acc: ACC_NONE, wt: WT_1};
			4'd6:  u = '{a: OPN_B,   b: OPN_P2, dst: DST_NONE, acc: ACC_X,    wt: WT_3};
			4'd7:  u = '{a: OPN_MT2, b: OPN_P1, dst: DST_NONE, acc: ACC_D,    wt: WT_3};
			4'd8:  u = '{a: OPN_MT,  b: OPN_T,  dst: DST_C,    acc: ACC_NONE, wt: WT_1};
			4'd9:  u = '{a: OPN_C,   b: OPN_PD, dst: DST_NONE, acc: ACC_D,    wt: WT_6};
			4'd10: u = '{a: OPN_T2,  b: OPN_PC, dst: DST_NONE, acc: ACC_D,    wt: WT_3};
			default: u = '{a: OPN_T, b: OPN_T, dst: DST_NONE, acc: ACC_NONE, wt: WT_1};
		endcase
		return u;
	endfunction

	// Control and configuration
	state_t              state_q;
	logic [PC_W-1:0]     pc_q;
	logic [QCNT_W-1:0]   cnt_q;
	logic [STEP_W-1:0]   step_q;
	logic                mode_y_q;
	logic                out_valid_q;
	word_t               out_value_q;
	word_t               ctrl_x1_q, ctrl_x2_q, ctrl_y1_q, ctrl_y2_q;

	// Datapath
	word_t                    x_q, t_q, t2_q, mt2_q, a_q, b_q, c_q;
	logic signed [ACC_W-1:0]  acc_x_q, acc_d_q;
	logic [DIV_W-1:0]         dvd_q, dvs_q;
	logic [Q_W-1:0]           q_q;
	logic                     neg_q;

	logic lin_acc;
	assign lin_acc      = linear.valid && linear.ready;
	assign linear.ready = (state_q == ST_IDLE);
	assign eased.valid       = out_valid_q;
	assign eased.eased_value = out_value_q;

	// Operand selection
	uop_t                     uop;
	word_t                    mt, p1, p2, pc_term, opa, b_mag, p_mag;
	logic signed [WORD_W:0]   pd, opb;
	logic                     b_neg;
	logic [PROD_W-1:0]        prod, psum;
	logic signed [ACC_W-1:0]  p_ext, p_val, p_wt;

	always_comb begin
		uop     = uop_at(pc_q);
		mt      = ONE - t_q;
		p1      = mode_y_q ? ctrl_y1_q : ctrl_x1_q;
		p2      = mode_y_q ? ctrl_y2_q : ctrl_x2_q;
		pd      = signed'({1'b0, p2}) - signed'({1'b0, p1});
		pc_term = ONE - p2;

		unique case (uop.a)
			OPN_T:   opa = t_q;
			OPN_MT:  opa = mt;
			OPN_T2:  opa = t2_q;
			OPN_MT2: opa = mt2_q;
			OPN_A:   opa = a_q;
			OPN_B:   opa = b_q;
			OPN_C:   opa = c_q;
			default: opa = '0;
		endcase

		unique case (uop.b)
			OPN_T:   opb = signed'({1'b0, t_q});
			OPN_MT:  opb = signed'({1'b0, mt});
			OPN_T2:  opb = signed'({1'b0, t2_q});
			OPN_P1:  opb = signed'({1'b0, p1});
			OPN_P2:  opb = signed'({1'b0, p2});
			OPN_PD:  opb = pd;
			OPN_PC:  opb = signed'({1'b0, pc_term});
			default: opb = '0;
		endcase

		// Shared multiplier: magnitude product, round half away from zero
		b_neg = opb[WORD_W];
		b_mag = b_neg ? WORD_W'(-opb) : WORD_W'(opb);
		prod  = PROD_W'(opa) * PROD_W'(b_mag);
		psum  = prod + RND_HALF;
		p_mag = psum[FRAC_BITS +: WORD_W];
		p_ext = signed'(ACC_W'(p_mag));
		p_val = b_neg ? -p_ext : p_ext;

		unique case (uop.wt)
			WT_1:    p_wt = p_val;
			WT_3:    p_wt = p_val + (p_val <<< 1);
			WT_6:    p_wt = (p_val <<< 1) + (p_val <<< 2);
			default: p_wt = p_val;
		endcase
	end

	// Newton check, divider compare, t update and y clamp
	logic signed [ACC_W-1:0] err;
	logic [ACC_W-1:0]        err_mag, d_mag;
	logic                    d_zero, div_ge;
	logic [Q_W-1:0]          q_sat;
	logic signed [TN_W-1:0]  t_ext, q_ext, t_new;
	word_t                   t_next, y_clamped;

	always_comb begin
		err     = acc_x_q - signed'(ACC_W'(x_q));
		err_mag = err[ACC_W-1] ? ACC_W'(-err) : ACC_W'(err);
		d_mag   = acc_d_q[ACC_W-1] ? ACC_W'(-acc_d_q) : ACC_W'(acc_d_q);
		d_zero  = (acc_d_q == '0);
		div_ge  = (dvd_q >= dvs_q);

		q_sat = (q_q > Q_MAX) ? Q_MAX : q_q;
		t_ext = signed'(TN_W'(t_q));
		q_ext = signed'(TN_W'(q_sat));
		t_new = neg_q ? (t_ext + q_ext) : (t_ext - q_ext);
		if (t_new < 0) begin
			t_next = '0;
		end else if (t_new > signed'(TN_W'(ONE))) begin
			t_next = ONE;
		end else begin
			t_next = t_new[WORD_W-1:0];
		end

		if (acc_x_q < 0) begin
			y_clamped = '0;
		end else if (acc_x_q > signed'(ACC_W'(ONE))) begin
			y_clamped = ONE;
		end else begin
			y_clamped = acc_x_q[WORD_W-1:0];
		end
	end

	// Sequencer, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			mode_y_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			ctrl_x1_q   <= CTRL_X1_RST;
			ctrl_x2_q   <= CTRL_X2_RST;
			ctrl_y1_q   <= CTRL_Y1_RST;
			ctrl_y2_q   <= CTRL_Y2_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CTRL_X1: ctrl_x1_q <= sat_unit(cfg_data);
					CFG_CTRL_X2: ctrl_x2_q <= sat_unit(cfg_data);
					CFG_CTRL_Y1: ctrl_y1_q <= sat_unit(cfg_data);
					CFG_CTRL_Y2: ctrl_y2_q <= sat_unit(cfg_data);
				endcase
			end

			// Drop a taken result; a finishing request loads its own below
			if (eased.ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (lin_acc) begin
						state_q  <= ST_EVAL;
						pc_q     <= '0;
						step_q   <= '0;
						mode_y_q <= 1'b0;
					end
				end
				ST_EVAL: begin
					if (pc_q == (mode_y_q ? PC_LAST_CURVE : PC_LAST_NEWTON)) begin
						pc_q    <= '0;
						state_q <= mode_y_q ? ST_FINISH : ST_CHECK;
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				ST_CHECK: begin
					// Flat slope: keep t and go straight to the y evaluation
					if (d_zero) begin
						mode_y_q <= 1'b1;
						state_q  <= ST_EVAL;
					end else begin
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == QCNT_W'(Q_W - 1)) begin
						state_q <= ST_UPDATE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_EVAL;
					if (step_q == STEP_W'(NEWTON_STEPS - 1)) begin
						mode_y_q <= 1'b1;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FINISH: begin
					// Hold until the previous result has been taken
					if (!out_valid_q || eased.ready) begin
						out_valid_q <= 1'b1;
						out_value_q <= y_clamped;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (lin_acc) begin
					x_q     <= sat_unit(linear.linear_t);
					t_q     <= sat_unit(linear.linear_t);
					acc_x_q <= '0;
					acc_d_q <= '0;
				end
			end
			ST_EVAL: begin
				unique case (uop.dst)
					DST_T2:  t2_q  <= p_mag;
					DST_MT2: mt2_q <= p_mag;
					DST_A:   a_q   <= p_mag;
					DST_B:   b_q   <= p_mag;
					DST_C:   c_q   <= p_mag;
					default: ;
				endcase
				unique case (uop.acc)
					ACC_X:   acc_x_q <= acc_x_q + p_wt;
					ACC_D:   acc_d_q <= acc_d_q + p_wt;
					default: ;
				endcase
			end
			ST_CHECK: begin
				dvd_q   <= DIV_W'(err_mag) << FRAC_BITS;
				dvs_q   <= DIV_W'(d_mag) << (Q_W - 1);
				q_q     <= '0;
				neg_q   <= err[ACC_W-1] ^ acc_d_q[ACC_W-1];
				acc_x_q <= '0;
				acc_d_q <= '0;
			end
			ST_DIV: begin
				// Restoring division, one quotient bit a cycle
				if (div_ge) begin
					dvd_q <= dvd_q - dvs_q;
				end
				q_q   <= {q_q[Q_W-2:0], div_ge};
				dvs_q <= dvs_q >> 1;
			end
			ST_UPDATE: begin
				t_q     <= t_next;
				acc_x_q <= '0;
				acc_d_q <= '0;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

/* tb/tb_cubic_bezier_easing.sv */
`timescale 1ns / 1ps
// Self-checking testbench for cubic_bezier_easing: valid/ready driver and monitor
// around a fixed-point Newton/Bezier predictor. Depends on cbe_pkg, cbe_if and the RTL.
module tb_cubic_bezier_easing;
	import cbe_pkg::*;

	localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
	localparam int     RUN_LIMIT  = 1500000;
	localparam int     HOLD_LEN   = 2000;
	localparam int     TAIL_WAIT  = 400;
	localparam int     RAND_ITEMS = 125;

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	word_t    cfg_data;

	cbe_linear_if linear_ch();
	cbe_eased_if  eased_ch();

	cubic_bezier_easing u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.linear   (linear_ch),
		.eased    (eased_ch)
	);

	// Control points as the block holds them, already saturated
	longint cp_x1, cp_x2, cp_y1, cp_y2;

	word_t linear_pending[$];
	word_t eased_due[$];
	int    fail_count = 0;
	int    cycle_count = 0;
	int    src_idle_pct = 0;
	int    snk_idle_pct = 0;
	bit    hold_armed = 1'b0;

	function automatic longint unit_sat(word_t w);
		longint v;
		v = longint'(w);
		return (v > ONE_Q) ? ONE_Q : v;
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v < 0)
			return 0;
		if (v > ONE_Q)
			return ONE_Q;
		return v;
	endfunction

	function automatic longint unsigned magn(longint a);
		return (a < 0) ? longint'(-a) : a;
	endfunction

	// Fixed-point product, rounded to nearest with ties away from zero
	function automatic longint qmul_round(longint a, longint b);
		longint unsigned p;
		p = (magn(a) * magn(b) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic longint bez_point(longint t, longint p1, longint p2);
		longint mt, t2, t3, mt2;
		mt  = ONE_Q - t;
		t2  = qmul_round(t, t);
		t3  = qmul_round(t2, t);
		mt2 = qmul_round(mt, mt);
		return 3 * qmul_round(qmul_round(mt2, t), p1)
			+ 3 * qmul_round(qmul_round(mt, t2), p2) + t3;
	endfunction

	function automatic longint bez_slope(longint t, longint p1, longint p2);
		longint mt, t2, mt2;
		mt  = ONE_Q - t;
		t2  = qmul_round(t, t);
		mt2 = qmul_round(mt, mt);
		return 3 * qmul_round(mt2, p1) + 6 * qmul_round(qmul_round(mt, t), p2 - p1)
			+ 3 * qmul_round(t2, ONE_Q - p2);
	endfunction

	function automatic word_t ease_predict(word_t raw);
		longint            x, t, err, d, stp;
		longint unsigned   q;
		x = unit_sat(raw);
		t = x;
		for (int i = 0; i < NEWTON_STEPS; i++) begin
			err = bez_point(t, cp_x1, cp_x2) - x;
			d   = bez_slope(t, cp_x1, cp_x2);
			// flat slope: keep the current parameter
			if (d == 0)
				break;
			q = (magn(err) << FRAC_BITS) / magn(d);
			if (q > longint'(2 * ONE_Q))
				q = 2 * ONE_Q;
			stp = ((err < 0) != (d < 0)) ? -longint'(q) : longint'(q);
			t = clamp_unit(t - stp);
		end
		return word_t'(clamp_unit(bez_point(t, cp_y1, cp_y2)));
	endfunction

	function automatic word_t pick_point();
		int r;
		r = $urandom_range(9);
		case (r)
			0: return '0;
			1: return ONE;
			2: return word_t'($urandom_range(2 * ONE - 1, ONE + 1));
			3: return word_t'($urandom);
			default: return word_t'($urandom_range(ONE, 0));
		endcase
	endfunction

	function automatic word_t pick_linear();
		int r;
		r = $urandom_range(19);
		case (r)
			0: return '0;
			1: return ONE;
			2: return word_t'($urandom);
			3: return word_t'($urandom_range(2 * ONE - 1, ONE + 1));
			4: return word_t'($urandom_range(15, 0));
			5: return word_t'($urandom_range(ONE, ONE - 15));
			default: return word_t'($urandom_range(ONE, 0));
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Request driver: take from the pending queue, idle at random when free
	always @(posedge clk) begin
		if (arst_n) begin
			if (linear_ch.valid && linear_ch.ready)
				eased_due.push_back(ease_predict(linear_ch.linear_t));
			if (!linear_ch.valid || linear_ch.ready) begin
				if (linear_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					linear_ch.valid    <= 1'b1;
					linear_ch.linear_t <= linear_pending.pop_front();
				end else begin
					linear_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver stalls
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk) begin
		word_t want;
		if (arst_n) begin
			if (eased_ch.valid && eased_ch.ready) begin
				if (eased_due.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result eased_value=%0d", $time,
						eased_ch.eased_value);
				end else begin
					want = eased_due.pop_front();
					if (eased_ch.eased_value !== want) begin
						fail_count++;
						$display("%0t: eased_value mismatch: expected %0d actual %0d",
							$time, want, eased_ch.eased_value);
					end
				end
			end
			// long hold-off so the block backs up and stalls its input
			if (hold_armed && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				eased_ch.ready <= 1'b0;
			end else begin
				eased_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	task automatic write_reg(cfg_idx_t idx, word_t val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_CTRL_X1: cp_x1 = unit_sat(val);
			CFG_CTRL_X2: cp_x2 = unit_sat(val);
			CFG_CTRL_Y1: cp_y1 = unit_sat(val);
			CFG_CTRL_Y2: cp_y2 = unit_sat(val);
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_points(word_t x1, word_t x2, word_t y1, word_t y2);
		write_reg(CFG_CTRL_X1, x1);
		write_reg(CFG_CTRL_X2, x2);
		write_reg(CFG_CTRL_Y1, y1);
		write_reg(CFG_CTRL_Y2, y2);
	endtask

	task automatic wait_drained();
		while (linear_pending.size() != 0 || linear_ch.valid || eased_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_items(word_t items[$]);
		@(negedge clk);
		foreach (items[i])
			linear_pending.push_back(items[i]);
	endtask

	initial begin
		word_t burst[$];
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_CTRL_X1;
		cfg_data            = '0;
		linear_ch.valid     = 1'b0;
		linear_ch.linear_t  = '0;
		eased_ch.ready      = 1'b0;
		cp_x1 = unit_sat(CTRL_X1_RST);
		cp_x2 = unit_sat(CTRL_X2_RST);
		cp_y1 = unit_sat(CTRL_Y1_RST);
		cp_y2 = unit_sat(CTRL_Y2_RST);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Default curve: field extremes and inputs above one
		burst = '{'0, ONE, word_t'('1), ONE + 1, 1, ONE - 1, ONE / 2, ONE / 4,
			3 * ONE / 4, word_t'(17'h0AAAA), word_t'(17'h15555)};
		queue_items(burst);
		wait_drained();

		// Slope flat at both ends: start at zero or one stops at once
		set_points('0, ONE, '0, ONE);
		burst = '{'0, ONE, ONE / 2, 1};
		queue_items(burst);
		wait_drained();

		// Slope flat in the middle; x1 written above one saturates
		set_points(word_t'('1), '0, ONE, '0);
		burst = '{ONE / 2, '0, ONE, ONE / 3, ONE / 2 + 1};
		queue_items(burst);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			set_points(pick_point(), pick_point(), pick_point(), pick_point());
			if (ph < 2) begin
				src_idle_pct <= 34;
				snk_idle_pct <= 76;
			end else if (ph < 4) begin
				src_idle_pct <= 76;
				snk_idle_pct <= 34;
			end else begin
				src_idle_pct <= 0;
				snk_idle_pct <= 0;
			end
			if (ph == 4)
				hold_armed <= 1'b1;
			burst.delete();
			for (int k = 0; k < RAND_ITEMS; k++)
				burst.push_back(pick_linear());
			queue_items(burst);
			wait_drained();
		end

		repeat (TAIL_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
rtl/cbe_pkg.sv
rtl/cbe_if.sv
rtl/cubic_bezier_easing.sv
tb/tb_cubic_bezier_easing.sv
